>>> design/srtf_tick_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_unit_assert.svh
// Assertion macros used by the tick scheduler unit.
// ----------------------------------------------------------------------------
`ifndef SRTF_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define SRTF_TICK_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SRTF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Types and constants of the shortest-remaining-time tick scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int TIME_W  = 16;
    localparam int TASK_W  = 4;
    localparam int CFG_W   = 5;
    localparam int DONE_W  = 5;

    localparam logic       MODE_LOAD = 1'b0;
    localparam logic       MODE_TICK = 1'b1;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [DONE_W-1:0] DONE_MAX = {DONE_W{1'b1}};

    typedef struct packed {
        logic              mode;
        logic [TASK_W-1:0] task_index;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_length;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic [TASK_W-1:0] running_task;
        logic              idle;
        logic              finished;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] turnaround_time;
        logic              all_done;
    } t_result;

    // best candidate handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] burst;
    } t_cand;

    // command broadcast to the cells
    typedef struct packed {
        logic              load;
        logic              dec;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] burst;
    } t_cell_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

>>> design/srtf_cell.sv
// ----------------------------------------------------------------------------
// srtf_cell
// One task entry: holds arrival, burst and remaining time, and passes the
// best candidate seen so far on to the next cell.
// ----------------------------------------------------------------------------
module srtf_cell
    import srtf_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 4,
    parameter int CW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic              i_sel,
    input  logic [TIME_W-1:0] i_clk_now,
    input  logic [CW-1:0]     i_count,
    input  logic              i_valid,
    input  t_cand             i_cand,
    input  logic [IDX_W-1:0]  i_cand_idx,
    output logic              o_valid,
    output t_cand             o_cand,
    output logic [IDX_W-1:0]  o_cand_idx
);

    logic [TIME_W-1:0] r_arr;
    logic [TIME_W-1:0] r_burst;
    logic [TIME_W-1:0] r_rem;
    logic              r_valid;
    t_cand             r_cand;
    logic [IDX_W-1:0]  r_cand_idx;
    logic              eligible;
    logic              take;

    assign eligible = (i_count > CW'(INDEX)) && (i_clk_now >= r_arr) && (r_rem != '0);
    assign take     = eligible && (!i_cand.found || (r_rem < i_cand.rem) ||
                      ((r_rem == i_cand.rem) && (r_arr < i_cand.arr)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_sel) begin
            r_arr   <= i_cmd.arr;
            r_burst <= i_cmd.burst;
            r_rem   <= i_cmd.burst;
        end else if (i_cmd.dec && i_sel) begin
            r_rem   <= r_rem - TIME_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cand     <= '{found: 1'b1, rem: r_rem, arr: r_arr, burst: r_burst};
            r_cand_idx <= IDX_W'(INDEX);
        end else begin
            r_cand     <= i_cand;
            r_cand_idx <= i_cand_idx;
        end
    end

    assign o_valid    = r_valid;
    assign o_cand     = r_cand;
    assign o_cand_idx = r_cand_idx;

endmodule

>>> design/srtf_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_unit
// Preemptive shortest-remaining-time scheduler over a row of task cells.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------
//  item in  | start, busy         | i_item   (t_item)
//  result   | o_strobe            | o_result (t_result)
//  config   | i_cfg_we            | i_cfg_data (task count)
//
// A load item completes in the cycle it is accepted and gives no result.
// A tick sends a candidate through the MAX_TASKS cells, one cell per cycle,
// so busy is high while the candidate is in the cells and the result strobes
// in the first cycle with busy low; the next tick can be taken in that same
// cycle. A tick after all tasks finished strobes its result the next cycle.
// Reset is synchronous; task tables are undefined until loaded.
// The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "srtf_tick_scheduler_unit_assert.svh"

module srtf_tick_scheduler_unit
    import srtf_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_item            i_item,
    output logic             o_strobe,
    output t_result          o_result,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int XW    = (IDX_W > TASK_W) ? IDX_W : TASK_W;

    t_state             r_state;
    t_state             n_state;
    logic [TIME_W-1:0]  r_clock;
    logic [DONE_W-1:0]  r_done_cnt;
    logic [CFG_W-1:0]   r_task_count;
    logic               r_strobe;
    t_result            r_result;
    logic               n_strobe;
    t_result            n_result;

    logic               accept;
    logic               tick_acc;
    logic               load_ok;
    logic               inject;
    logic               finish;
    logic [CW-1:0]      eff_count;
    logic               all_done_now;
    t_cell_cmd          cmd;
    logic [TIME_W-1:0]  clk_new;
    logic               fin;
    logic [DONE_W-1:0]  cnt_new;
    logic [TIME_W:0]    need;
    logic [XW-1:0]      tail_idx_x;

    logic               v_chain   [0:MAX_TASKS];
    t_cand              c_chain   [0:MAX_TASKS];
    logic [IDX_W-1:0]   idx_chain [0:MAX_TASKS];
    logic [MAX_TASKS-1:0] sel;

    assign accept   = start && !busy;
    assign tick_acc = accept && (i_item.mode == MODE_TICK);
    assign load_ok  = accept && (i_item.mode == MODE_LOAD) &&
                      (int'(i_item.task_index) < MAX_TASKS);

    always_comb begin
        if (r_task_count == '0) begin
            eff_count = CW'(1);
        end else if (CW'(r_task_count) > CW'(MAX_TASKS)) begin
            eff_count = CW'(MAX_TASKS);
        end else begin
            eff_count = CW'(r_task_count);
        end
    end

    assign all_done_now = CW'(r_done_cnt) >= eff_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_item.mode == MODE_TICK) && !all_done_now) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (v_chain[MAX_TASKS]) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy   = 1'b0;
        inject = 1'b0;
        finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                inject = start && (i_item.mode == MODE_TICK) && !all_done_now;
            end
            ST_SCAN: begin
                busy   = 1'b1;
                finish = v_chain[MAX_TASKS];
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    // cell row
    assign v_chain[0]   = inject;
    assign c_chain[0]   = '0;
    assign idx_chain[0] = '0;

    always_comb begin
        cmd.load  = load_ok;
        cmd.dec   = finish && c_chain[MAX_TASKS].found;
        cmd.arr   = i_item.arrival_time;
        cmd.burst = (i_item.burst_length == '0) ? TIME_W'(1) : i_item.burst_length;
    end

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        assign sel[g] = (cmd.load && (int'(i_item.task_index) == g)) ||
                        (cmd.dec && (int'(idx_chain[MAX_TASKS]) == g));

        srtf_cell #(
            .INDEX (g),
            .IDX_W (IDX_W),
            .CW    (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_sel      (sel[g]),
            .i_clk_now  (r_clock),
            .i_count    (eff_count),
            .i_valid    (v_chain[g]),
            .i_cand     (c_chain[g]),
            .i_cand_idx (idx_chain[g]),
            .o_valid    (v_chain[g+1]),
            .o_cand     (c_chain[g+1]),
            .o_cand_idx (idx_chain[g+1])
        );
    end

    // tick completion
    assign clk_new    = (r_clock == TIME_MAX) ? r_clock : r_clock + TIME_W'(1);
    assign fin        = c_chain[MAX_TASKS].found && (c_chain[MAX_TASKS].rem == TIME_W'(1));
    assign cnt_new    = (fin && (r_done_cnt != DONE_MAX)) ? r_done_cnt + DONE_W'(1)
                                                          : r_done_cnt;
    assign need       = {1'b0, c_chain[MAX_TASKS].burst} + {1'b0, c_chain[MAX_TASKS].arr};
    assign tail_idx_x = XW'(idx_chain[MAX_TASKS]);

    always_comb begin
        n_strobe = finish || (accept && (i_item.mode == MODE_TICK) && all_done_now);
        n_result = '0;
        if (finish) begin
            n_result.time_now = clk_new;
            n_result.idle     = !c_chain[MAX_TASKS].found;
            n_result.finished = fin;
            n_result.all_done = CW'(cnt_new) >= eff_count;
            if (c_chain[MAX_TASKS].found) begin
                n_result.running_task = tail_idx_x[TASK_W-1:0];
            end
            if (fin) begin
                n_result.turnaround_time = clk_new - c_chain[MAX_TASKS].arr;
                if ({1'b0, clk_new} > need) begin
                    n_result.waiting_time = clk_new - need[TIME_W-1:0];
                end
            end
        end else begin
            n_result.time_now = r_clock;
            n_result.idle     = 1'b1;
            n_result.all_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_clock      <= '0;
            r_done_cnt   <= '0;
            r_task_count <= CFG_W'(1);
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_task_count <= i_cfg_data;
            end
            if (load_ok) begin
                r_clock    <= '0;
                r_done_cnt <= '0;
            end else if (finish) begin
                r_clock    <= clk_new;
                r_done_cnt <= cnt_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `SRTF_ASSERT_IMP(a_strobe_not_busy, o_strobe, !busy, "result strobed while scanning")
    `SRTF_ASSERT_IMP(a_busy_fall_strobe, $fell(busy), o_strobe, "scan ended without a result")
    `SRTF_ASSERT_NXT(a_tick_progress, tick_acc, o_strobe || busy, "tick item dropped")
    `SRTF_ASSERT_IMP(a_idle_not_fin, o_strobe && o_result.idle, !o_result.finished, "idle tick reports completion")

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for srtf_tick_scheduler_unit. Loads task tables,
// switches the task count while the block is quiet and checks every tick
// result against a built-in shortest-remaining-time model. Covers tie
// breaking, zero bursts, count clamping, ticks after completion and random
// job sets under several sender idle rates.
// ----------------------------------------------------------------------------
module tb;
    import srtf_pkg::*;

    localparam int MAX_TASKS = 16;
    localparam int DRAIN = MAX_TASKS + 4;
    localparam int PHASE_ITEMS = 375;
    localparam longint CYCLE_LIMIT = 64'd400_000;

    class tick_board;
        logic [TIME_W-1:0] arr_tab [MAX_TASKS];
        logic [TIME_W-1:0] burst_tab [MAX_TASKS];
        logic [TIME_W-1:0] rem_tab [MAX_TASKS];
        logic [TIME_W-1:0] clk_val;
        logic [DONE_W-1:0] done_cnt;
        logic [CFG_W-1:0] task_cnt;
        t_result tick_reports [$];
        int errors;
        int loads;
        int ticks;
        int finishes;

        function new();
            for (int i = 0; i < MAX_TASKS; i++) begin
                arr_tab[i] = '0;
                burst_tab[i] = '0;
                rem_tab[i] = '0;
            end
            clk_val = '0;
            done_cnt = '0;
            task_cnt = 1;
        endfunction

        function void set_count(logic [CFG_W-1:0] v);
            task_cnt = v;
        endfunction

        // predict the effect of one accepted item
        function void note_item(t_item it);
            t_result r;
            int n;
            int best;
            bit found;
            logic [TIME_W:0] need;
            logic [TIME_W-1:0] b;
            n = (task_cnt == 0) ? 1 : (task_cnt > MAX_TASKS) ? MAX_TASKS : int'(task_cnt);
            if (it.mode == MODE_LOAD) begin
                b = (it.burst_length == '0) ? TIME_W'(1) : it.burst_length;
                arr_tab[it.task_index] = it.arrival_time;
                burst_tab[it.task_index] = b;
                rem_tab[it.task_index] = b;
                clk_val = '0;
                done_cnt = '0;
                loads++;
                return;
            end
            ticks++;
            r = '0;
            r.idle = 1'b1;
            found = 1'b0;
            best = 0;
            if (done_cnt < n) begin
                for (int i = 0; i < n; i++) begin
                    if (clk_val >= arr_tab[i] && rem_tab[i] != '0) begin
                        if (!found || rem_tab[i] < rem_tab[best] ||
                            (rem_tab[i] == rem_tab[best] && arr_tab[i] < arr_tab[best])) begin
                            best = i;
                            found = 1'b1;
                        end
                    end
                end
                if (clk_val != TIME_MAX) clk_val = clk_val + 1'b1;
                if (found) begin
                    r.idle = 1'b0;
                    r.running_task = TASK_W'(best);
                    rem_tab[best] = rem_tab[best] - 1'b1;
                    if (rem_tab[best] == '0) begin
                        need = {1'b0, burst_tab[best]} + {1'b0, arr_tab[best]};
                        r.finished = 1'b1;
                        r.turnaround_time = clk_val - arr_tab[best];
                        r.waiting_time = ({1'b0, clk_val} > need) ?
                                         clk_val - need[TIME_W-1:0] : '0;
                        if (done_cnt != DONE_MAX) done_cnt = done_cnt + 1'b1;
                        finishes++;
                    end
                end
            end
            r.time_now = clk_val;
            r.all_done = (done_cnt >= n);
            tick_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (tick_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            want = tick_reports.pop_front();
            check_field("time_now", want.time_now, got.time_now);
            check_field("running_task", TIME_W'(want.running_task), TIME_W'(got.running_task));
            check_field("idle", TIME_W'(want.idle), TIME_W'(got.idle));
            check_field("finished", TIME_W'(want.finished), TIME_W'(got.finished));
            check_field("waiting_time", want.waiting_time, got.waiting_time);
            check_field("turnaround_time", want.turnaround_time, got.turnaround_time);
            check_field("all_done", TIME_W'(want.all_done), TIME_W'(got.all_done));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_item i_item = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic busy;
    logic o_strobe;
    t_result o_result;

    tick_board sb;
    int idle_pct = 0;
    int sent = 0;
    int cfg_writes = 0;
    longint cycles = 0;

    srtf_tick_scheduler_unit #(
        .MAX_TASKS (MAX_TASKS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_item(i_item);
            if (o_strobe) sb.check_result(o_result);
        end
    end

    function automatic t_item load_item(int idx, int arr, int bur);
        t_item it;
        it.mode = MODE_LOAD;
        it.task_index = TASK_W'(idx);
        it.arrival_time = TIME_W'(arr);
        it.burst_length = TIME_W'(bur);
        return it;
    endfunction

    function automatic t_item tick_item();
        t_item it;
        it.mode = MODE_TICK;
        it.task_index = TASK_W'($urandom_range(MAX_TASKS - 1));
        it.arrival_time = TIME_W'($urandom);
        it.burst_length = TIME_W'($urandom);
        return it;
    endfunction

    task automatic send(input t_item it);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    // hold off until every tick result is back and the block has settled
    task automatic quiesce();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.tick_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_count(v);
        cfg_writes++;
    endtask

    task automatic directed();
        // ties on remaining time, zero burst, unused extreme entry
        write_cfg(CFG_W'(3));
        send(load_item(0, 0, 2));
        send(load_item(1, 0, 2));
        send(load_item(2, 1, 0));
        send(load_item(MAX_TASKS - 1, 16'hFFFF, 16'hFFFF));
        repeat (7) send(tick_item());
        quiesce();
        // count zero acts as one; idle ticks before arrival
        write_cfg(CFG_W'(0));
        send(load_item(0, 2, 1));
        repeat (4) send(tick_item());
        quiesce();
    endtask

    task automatic run_job();
        int pick;
        int cfg;
        int n;
        int span;
        int max_arr;
        int work;
        int j;
        int k;
        int tmp;
        int limit;
        int arr_v;
        int bur_v;
        int order [MAX_TASKS];
        pick = $urandom_range(9);
        case (pick)
            0: cfg = 0;
            1: cfg = 31;
            2: cfg = $urandom_range(30, MAX_TASKS + 1);
            3: cfg = MAX_TASKS;
            default: cfg = $urandom_range(MAX_TASKS, 1);
        endcase
        quiesce();
        write_cfg(CFG_W'(cfg));
        n = (cfg == 0) ? 1 : (cfg > MAX_TASKS) ? MAX_TASKS : cfg;
        span = ($urandom_range(3) == 0) ? 60 : 10;
        for (j = 0; j < n; j++) order[j] = j;
        for (j = n - 1; j > 0; j--) begin
            k = $urandom_range(j);
            tmp = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        max_arr = 0;
        work = 0;
        for (j = 0; j < n; j++) begin
            arr_v = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(span);
            tmp = $urandom_range(19);
            bur_v = (tmp == 0) ? 0 : (tmp == 1) ? $urandom_range(65535) : $urandom_range(8, 1);
            if (arr_v > max_arr) max_arr = arr_v;
            work += (bur_v == 0) ? 1 : bur_v;
            send(load_item(order[j], arr_v, bur_v));
            if (n < MAX_TASKS && $urandom_range(9) == 0)
                send(load_item($urandom_range(MAX_TASKS - 1, n), $urandom, $urandom));
        end
        limit = max_arr + work + 3;
        if (limit > 150) limit = 150;
        for (j = 0; j < limit; j++) begin
            // occasional reload mid-run restarts the clock
            if ($urandom_range(39) == 0)
                send(load_item($urandom_range(n - 1), $urandom_range(span),
                               $urandom_range(8, 1)));
            send(tick_item());
        end
    endtask

    initial begin
        int idle_plan [4];
        int target;
        idle_plan = '{0, 74, 7, 0};
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();

        for (int p = 0; p < 4; p++) begin
            idle_pct = idle_plan[p];
            target = sent + PHASE_ITEMS;
            while (sent < target) run_job();
        end

        quiesce();
        $display("Ran %0d loads and %0d ticks, %0d task completions, %0d count settings,",
                 sb.loads, sb.ticks, sb.finishes, cfg_writes);
        $display("with tie breaks, count clamping, idle and finished ticks at several idle rates.");
        if (sb.errors == 0 && sb.tick_reports.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/srtf_pkg.sv
design/srtf_cell.sv
design/srtf_tick_scheduler_unit.sv
test/tb.sv
